// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the sensor_tick_conditioner module.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/stc_pkg.sv -----
`timescale 1ns / 1ps
package stc_pkg;

    // Field widths
    localparam int TS_W     = 32;
    localparam int LUX_W    = 24;
    localparam int TEMP_W   = 16;
    localparam int HUM_W    = 15;
    localparam int WEIGHT_W = 20;
    localparam int ALPHA_W  = 16;
    localparam int WIN_W    = 16;
    localparam int RUN_W    = 4;
    localparam int SMOOTH_W = 40;
    localparam int FRAC_W   = 16;

    // Stream word widths
    localparam int IN_BITS  = TS_W + LUX_W + 3 * TEMP_W + HUM_W + 1 + WEIGHT_W + 1;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = LUX_W + TEMP_W + HUM_W + 3 + TS_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LUX_ALPHA     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LUX_HYST      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROOM_NEEDED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROOM_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BED_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BED_SETTLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_WINDOW    = 3'd6;

    // Register reset values
    localparam logic [ALPHA_W-1:0]  RST_LUX_ALPHA     = 16'd3277;
    localparam logic [LUX_W-1:0]    RST_LUX_HYST      = 24'd256;
    localparam logic [RUN_W-1:0]    RST_ROOM_NEEDED   = 4'd3;
    localparam logic [TS_W-1:0]     RST_ROOM_HOLD     = 32'd30000;
    localparam logic [WEIGHT_W-1:0] RST_BED_THRESHOLD = 20'd15000;
    localparam logic [TS_W-1:0]     RST_BED_SETTLE    = 32'd5000;
    localparam logic [WIN_W-1:0]    RST_TAP_WINDOW    = 16'd300;

    // Tick schedule
    localparam int LUX_EVERY  = 10;
    localparam int TEMP_EVERY = 100;
    localparam int BED_EVERY  = 5;
    localparam int PHASE_MOD  = 100;
    localparam int PHASE_W    = $clog2(PHASE_MOD);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_MOD - 1);
    localparam logic [RUN_W-1:0]   RUN_MAX    = 4'd15;

    // Mark the phases on which a filter with the given spacing runs
    function automatic logic [PHASE_MOD-1:0] phase_hits(input int every);
        logic [PHASE_MOD-1:0] m;
        int k;
        m = '0;
        k = 0;
        for (int i = 0; i < PHASE_MOD; i++) begin
            m[i] = (k == 0);
            k = (k == every - 1) ? 0 : k + 1;
        end
        return m;
    endfunction

    localparam logic [PHASE_MOD-1:0] LUX_HITS  = phase_hits(LUX_EVERY);
    localparam logic [PHASE_MOD-1:0] TEMP_HITS = phase_hits(TEMP_EVERY);
    localparam logic [PHASE_MOD-1:0] BED_HITS  = phase_hits(BED_EVERY);

    // Control from the pipeline to the lux filter
    typedef struct packed {
        logic mul_en;   // load products for the word in the input stage
        logic upd_en;   // commit the smoothed value for the word in the middle stage
    } lux_ctrl_t;

endpackage

// ----- rtl/stc_lux_filter.sv -----
`timescale 1ns / 1ps
module stc_lux_filter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  stc_pkg::lux_ctrl_t         ctrl,
    input  logic [stc_pkg::LUX_W-1:0]  raw_lux,
    input  logic [stc_pkg::ALPHA_W-1:0] alpha,
    input  logic [stc_pkg::LUX_W-1:0]  hysteresis,
    output logic [stc_pkg::LUX_W-1:0]  lux_value
);
    import stc_pkg::*;

    localparam int DIFF_W = SMOOTH_W + 1;
    localparam int LO_W   = 24;
    localparam int HI_W   = DIFF_W - LO_W;
    localparam int PH_W   = 2 * HI_W;
    localparam int PL_W   = LO_W + ALPHA_W;
    localparam int SUM_W  = PH_W + (LO_W - FRAC_W);

    logic [SMOOTH_W-1:0]      smooth_reg;
    logic [LUX_W-1:0]         shown_reg;
    logic signed [PH_W-1:0]   ph_reg;
    logic [PL_W-1:0]          pl_reg;

    logic signed [DIFF_W-1:0] step;
    logic signed [HI_W-1:0]   step_hi;
    logic [LO_W-1:0]          step_lo;
    logic signed [HI_W-1:0]   alpha_s;
    logic signed [PH_W-1:0]   ph_next;
    logic [PL_W-1:0]          pl_next;
    logic [SUM_W-1:0]         sum;
    logic [SMOOTH_W-1:0]      smooth_next;
    logic [DIFF_W-1:0]        gap;
    logic [SMOOTH_W-1:0]      gap_mag;
    logic                     moved;
    logic [LUX_W-1:0]         shown_next;

    // Split the step toward the new sample into two narrow products:
    // new = smooth + floor((sample - smooth) * alpha / 2^16)
    always_comb
    begin
        step    = $signed({1'b0, raw_lux, {FRAC_W{1'b0}}}) - $signed({1'b0, smooth_reg});
        step_hi = step[DIFF_W-1:LO_W];
        step_lo = step[LO_W-1:0];
        alpha_s = $signed({1'b0, alpha});
        ph_next = step_hi * alpha_s;
        pl_next = step_lo * alpha;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
        end
    end

    // Recombine the products and apply the hysteresis
    always_comb
    begin
        sum = SUM_W'(smooth_reg)
            + SUM_W'({ph_reg, {(LO_W - FRAC_W){1'b0}}})
            + SUM_W'(pl_reg[PL_W-1:FRAC_W]);
        smooth_next = sum[SMOOTH_W-1:0];
        gap         = {1'b0, smooth_next} - {1'b0, shown_reg, {FRAC_W{1'b0}}};
        gap_mag     = gap[DIFF_W-1] ? SMOOTH_W'(-gap) : gap[SMOOTH_W-1:0];
        moved       = gap_mag >= {hysteresis, {FRAC_W{1'b0}}};
        shown_next  = moved ? smooth_next[SMOOTH_W-1:FRAC_W] : shown_reg;
        lux_value   = ctrl.upd_en ? shown_next : shown_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
            shown_reg  <= '0;
        end
        else if (ctrl.upd_en)
        begin
            smooth_reg <= smooth_next;
            shown_reg  <= shown_next;
        end
    end

endmodule

// ----- rtl/sensor_tick_conditioner.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Word
// s_axis    in         one 100 ms sensor tick (timestamp, lux, temps, humidity, flags)
// m_axis    out        one conditioned snapshot per tick
// cfg       in         register write: cfg_index selects, cfg_data carries the value
//
// Three register stages: input, middle (products and all non-lux state), output.
// One tick is accepted per cycle unless m_axis stalls. The lux multiply spans input
// and middle stages; two lux ticks in a row would hold the input stage until the first
// leaves the middle stage, which cannot happen with lux updates on every tenth tick.
// rst_n clears all state and loads register defaults; payload registers are not reset.
// A stalled m_axis holds its word while earlier stages keep filling.
module sensor_tick_conditioner (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // timestamp_ms, raw_lux, temp_sample_a, temp_sample_b, temp_sample_c,
    // humidity_raw, presence_raw, weight_grams, tap_level, zero fill
    input  logic [stc_pkg::IN_W-1:0]        s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // lux_reported, temperature_median, humidity_latched, room_present,
    // bed_present, double_tapped, updated_ms, zero fill
    output logic [stc_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import stc_pkg::*;
    `include "assert_macros.svh"

    // Configuration registers
    logic [ALPHA_W-1:0]  lux_alpha_reg;
    logic [LUX_W-1:0]    lux_hyst_reg;
    logic [RUN_W-1:0]    room_needed_reg;
    logic [TS_W-1:0]     room_hold_reg;
    logic [WEIGHT_W-1:0] bed_threshold_reg;
    logic [TS_W-1:0]     bed_settle_reg;
    logic [WIN_W-1:0]    tap_window_reg;

    // Input stage
    logic                       s0_valid_reg;
    logic [TS_W-1:0]            s0_ts_reg;
    logic [LUX_W-1:0]           s0_lux_reg;
    logic signed [TEMP_W-1:0]   s0_ta_reg;
    logic signed [TEMP_W-1:0]   s0_tb_reg;
    logic signed [TEMP_W-1:0]   s0_tc_reg;
    logic [HUM_W-1:0]           s0_hum_reg;
    logic                       s0_pres_reg;
    logic [WEIGHT_W-1:0]        s0_weight_reg;
    logic                       s0_tap_reg;

    // Running state
    logic [PHASE_W-1:0] phase_reg;
    logic [TEMP_W-1:0]  temp_held_reg;
    logic [HUM_W-1:0]   hum_held_reg;
    logic               room_state_reg;
    logic [RUN_W-1:0]   room_run_reg;
    logic [TS_W-1:0]    room_seen_reg;
    logic               bed_state_reg;
    logic               bed_cand_reg;
    logic [TS_W-1:0]    bed_since_reg;
    logic               tap_pending_reg;
    logic [TS_W-1:0]    tap_last_reg;
    logic               tap_prev_reg;

    // Middle stage
    logic               s1_valid_reg;
    logic               s1_lux_reg;
    logic [TEMP_W-1:0]  s1_temp_reg;
    logic [HUM_W-1:0]   s1_hum_reg;
    logic               s1_room_reg;
    logic               s1_bed_reg;
    logic               s1_pulse_reg;
    logic [TS_W-1:0]    s1_ts_reg;

    // Output stage
    logic               out_valid_reg;
    logic [LUX_W-1:0]   out_lux_reg;
    logic [TEMP_W-1:0]  out_temp_reg;
    logic [HUM_W-1:0]   out_hum_reg;
    logic               out_room_reg;
    logic               out_bed_reg;
    logic               out_pulse_reg;
    logic [TS_W-1:0]    out_ts_reg;

    // Next values
    logic [PHASE_W-1:0] phase_next;
    logic [TEMP_W-1:0]  temp_held_next;
    logic [HUM_W-1:0]   hum_held_next;
    logic               room_state_next;
    logic [RUN_W-1:0]   room_run_next;
    logic [TS_W-1:0]    room_seen_next;
    logic               bed_state_next;
    logic               bed_cand_next;
    logic [TS_W-1:0]    bed_since_next;
    logic               tap_pending_next;
    logic [TS_W-1:0]    tap_last_next;
    logic               pulse_next;

    // Pipeline control
    logic       out_open;
    logic       s1_adv;
    logic       s1_free;
    logic       hazard;
    logic       s0_go;
    logic       lux_tick;
    logic       temp_tick;
    logic       bed_tick;
    lux_ctrl_t  lux_ctrl;
    logic [LUX_W-1:0] lux_value;

    // Scratch for the per-tick logic
    logic [RUN_W-1:0]          run_inc;
    logic                      cand;
    logic                      fall;
    logic [TS_W-1:0]           tap_dt;
    logic                      in_window;
    logic signed [TEMP_W-1:0]  t_lo;
    logic signed [TEMP_W-1:0]  t_hi;
    logic signed [TEMP_W-1:0]  t_mid;

    // Accept register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lux_alpha_reg     <= RST_LUX_ALPHA;
            lux_hyst_reg      <= RST_LUX_HYST;
            room_needed_reg   <= RST_ROOM_NEEDED;
            room_hold_reg     <= RST_ROOM_HOLD;
            bed_threshold_reg <= RST_BED_THRESHOLD;
            bed_settle_reg    <= RST_BED_SETTLE;
            tap_window_reg    <= RST_TAP_WINDOW;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LUX_ALPHA:     lux_alpha_reg     <= cfg_data[ALPHA_W-1:0];
                REG_LUX_HYST:      lux_hyst_reg      <= cfg_data[LUX_W-1:0];
                REG_ROOM_NEEDED:   room_needed_reg   <= cfg_data[RUN_W-1:0];
                REG_ROOM_HOLD:     room_hold_reg     <= cfg_data[TS_W-1:0];
                REG_BED_THRESHOLD: bed_threshold_reg <= cfg_data[WEIGHT_W-1:0];
                REG_BED_SETTLE:    bed_settle_reg    <= cfg_data[TS_W-1:0];
                REG_TAP_WINDOW:    tap_window_reg    <= cfg_data[WIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Handshake chain, back to front
    always_comb
    begin
        lux_tick  = LUX_HITS[phase_reg];
        temp_tick = TEMP_HITS[phase_reg];
        bed_tick  = BED_HITS[phase_reg];
        out_open  = !out_valid_reg || m_axis_tready;
        s1_adv    = s1_valid_reg && out_open;
        s1_free   = !s1_valid_reg || s1_adv;
        hazard    = s1_valid_reg && s1_lux_reg && lux_tick;
        s0_go     = s0_valid_reg && s1_free && !hazard;
        s_axis_tready   = !s0_valid_reg || s0_go;
        lux_ctrl.mul_en = s0_go && lux_tick;
        lux_ctrl.upd_en = s1_adv && s1_lux_reg;
    end

    // Capture incoming words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s0_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s0_ts_reg     <= s_axis_tdata[31:0];
            s0_lux_reg    <= s_axis_tdata[55:32];
            s0_ta_reg     <= s_axis_tdata[71:56];
            s0_tb_reg     <= s_axis_tdata[87:72];
            s0_tc_reg     <= s_axis_tdata[103:88];
            s0_hum_reg    <= s_axis_tdata[118:104];
            s0_pres_reg   <= s_axis_tdata[119];
            s0_weight_reg <= s_axis_tdata[139:120];
            s0_tap_reg    <= s_axis_tdata[140];
        end
    end

    // Per-tick state update for everything but lux
    always_comb
    begin
        phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;

        // median of three
        t_lo  = (s0_ta_reg < s0_tb_reg) ? s0_ta_reg : s0_tb_reg;
        t_hi  = (s0_ta_reg < s0_tb_reg) ? s0_tb_reg : s0_ta_reg;
        priority if (s0_tc_reg <= t_lo)
            t_mid = t_lo;
        else if (s0_tc_reg >= t_hi)
            t_mid = t_hi;
        else
            t_mid = s0_tc_reg;
        temp_held_next = temp_tick ? t_mid : temp_held_reg;
        hum_held_next  = temp_tick ? s0_hum_reg : hum_held_reg;

        // room presence: count asserts, release after the hold time
        run_inc = (room_run_reg == RUN_MAX) ? room_run_reg : room_run_reg + 1'b1;
        if (s0_pres_reg)
        begin
            room_run_next   = run_inc;
            room_state_next = (run_inc >= room_needed_reg) ? 1'b1 : room_state_reg;
            room_seen_next  = s0_ts_reg;
        end
        else
        begin
            room_run_next   = '0;
            room_state_next = (room_state_reg
                               && (s0_ts_reg - room_seen_reg) >= room_hold_reg)
                              ? 1'b0 : room_state_reg;
            room_seen_next  = room_seen_reg;
        end

        // bed presence: follow the candidate once it has settled
        cand           = s0_weight_reg >= bed_threshold_reg;
        bed_cand_next  = bed_cand_reg;
        bed_since_next = bed_since_reg;
        bed_state_next = bed_state_reg;
        if (bed_tick)
        begin
            if (cand != bed_cand_reg)
            begin
                bed_cand_next  = cand;
                bed_since_next = s0_ts_reg;
            end
            else if ((s0_ts_reg - bed_since_reg) >= bed_settle_reg)
            begin
                bed_state_next = bed_cand_reg;
            end
        end

        // double tap: a second falling edge within the window of the first
        fall      = tap_prev_reg && !s0_tap_reg;
        tap_dt    = s0_ts_reg - tap_last_reg;
        in_window = tap_dt <= TS_W'(tap_window_reg);
        tap_pending_next = tap_pending_reg;
        tap_last_next    = tap_last_reg;
        pulse_next       = 1'b0;
        if (!fall)
        begin
            if (tap_pending_reg && !in_window)
                tap_pending_next = 1'b0;
        end
        else if (tap_pending_reg && in_window)
        begin
            tap_pending_next = 1'b0;
            tap_last_next    = s0_ts_reg;
            pulse_next       = 1'b1;
        end
        else
        begin
            tap_pending_next = 1'b1;
            tap_last_next    = s0_ts_reg;
        end
    end

    // Commit state as a word leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            temp_held_reg   <= '0;
            hum_held_reg    <= '0;
            room_state_reg  <= 1'b0;
            room_run_reg    <= '0;
            room_seen_reg   <= '0;
            bed_state_reg   <= 1'b0;
            bed_cand_reg    <= 1'b0;
            bed_since_reg   <= '0;
            tap_pending_reg <= 1'b0;
            tap_last_reg    <= '0;
            tap_prev_reg    <= 1'b1;
        end
        else if (s0_go)
        begin
            phase_reg       <= phase_next;
            temp_held_reg   <= temp_held_next;
            hum_held_reg    <= hum_held_next;
            room_state_reg  <= room_state_next;
            room_run_reg    <= room_run_next;
            room_seen_reg   <= room_seen_next;
            bed_state_reg   <= bed_state_next;
            bed_cand_reg    <= bed_cand_next;
            bed_since_reg   <= bed_since_next;
            tap_pending_reg <= tap_pending_next;
            tap_last_reg    <= tap_last_next;
            tap_prev_reg    <= s0_tap_reg;
        end
    end

    // Middle stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_lux_reg   <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= s0_go;
            s1_lux_reg   <= s0_go && lux_tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_go)
        begin
            s1_temp_reg  <= temp_held_next;
            s1_hum_reg   <= hum_held_next;
            s1_room_reg  <= room_state_next;
            s1_bed_reg   <= bed_state_next;
            s1_pulse_reg <= pulse_next;
            s1_ts_reg    <= s0_ts_reg;
        end
    end

    stc_lux_filter u_lux (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lux_ctrl),
        .raw_lux    (s0_lux_reg),
        .alpha      (lux_alpha_reg),
        .hysteresis (lux_hyst_reg),
        .lux_value  (lux_value)
    );

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_open)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_lux_reg   <= lux_value;
            out_temp_reg  <= s1_temp_reg;
            out_hum_reg   <= s1_hum_reg;
            out_room_reg  <= s1_room_reg;
            out_bed_reg   <= s1_bed_reg;
            out_pulse_reg <= s1_pulse_reg;
            out_ts_reg    <= s1_ts_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, out_ts_reg, out_pulse_reg,
                            out_bed_reg, out_room_reg, out_hum_reg, out_temp_reg,
                            out_lux_reg};

    `STC_ASSERT(a_phase_range, phase_reg <= PHASE_LAST, "tick phase out of range")
    `STC_ASSERT(a_lux_no_overlap, !(lux_ctrl.mul_en && s1_valid_reg && s1_lux_reg),
        "lux product taken while previous lux update pending")
    `STC_ASSERT_NEXT(a_pulse_clears, s0_go && pulse_next, !tap_pending_reg,
        "tap still pending after a double tap")
    `STC_ASSERT_NEXT(a_room_seen, s0_go && s0_pres_reg,
        room_seen_reg == $past(s0_ts_reg) && room_state_reg == $past(room_state_next),
        "room presence not stamped with tick time")

endmodule

// ----- bench/sensor_tick_conditioner_tb.sv -----
`timescale 1ns / 1ps
module sensor_tick_conditioner_tb;
    import stc_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_SLACK    = 8;
    localparam int LONG_HOLD      = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 166;
    localparam int QUIET_TAIL     = 100;
    localparam int MAX_PRINTS     = 20;

    // Index past the end of the register map; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef enum int {
        SET_LOW,
        SET_HIGH,
        SET_RANDOM_A,
        SET_RANDOM_B,
        SET_DEFAULT
    } setting_e;

    // One tick as packed on s_axis_tdata, last member in the lowest bits
    typedef struct packed {
        logic                tap_level;
        logic [WEIGHT_W-1:0] weight;
        logic                presence;
        logic [HUM_W-1:0]    humidity;
        logic [TEMP_W-1:0]   temp_c;
        logic [TEMP_W-1:0]   temp_b;
        logic [TEMP_W-1:0]   temp_a;
        logic [LUX_W-1:0]    lux;
        logic [TS_W-1:0]     stamp;
    } tick_t;

    // One snapshot as packed on m_axis_tdata
    typedef struct packed {
        logic [TS_W-1:0]     updated;
        logic                tapped;
        logic                bed;
        logic                room;
        logic [HUM_W-1:0]    humidity;
        logic [TEMP_W-1:0]   temp;
        logic [LUX_W-1:0]    lux;
    } snapshot_t;

    typedef struct {
        logic [ALPHA_W-1:0]  alpha;
        logic [LUX_W-1:0]    hyst;
        logic [RUN_W-1:0]    needed;
        logic [TS_W-1:0]     hold_ms;
        logic [WEIGHT_W-1:0] threshold;
        logic [TS_W-1:0]     settle_ms;
        logic [WIN_W-1:0]    window_ms;
    } knobs_t;

    // Tracks the conditioner state and queues the snapshot each tick should produce
    class tick_scoreboard;
        logic [ALPHA_W-1:0]  alpha;
        logic [LUX_W-1:0]    hyst;
        logic [RUN_W-1:0]    needed;
        logic [TS_W-1:0]     hold_ms;
        logic [WEIGHT_W-1:0] threshold;
        logic [TS_W-1:0]     settle_ms;
        logic [WIN_W-1:0]    window_ms;

        int unsigned         phase;
        logic [SMOOTH_W-1:0] lux_avg;
        logic [LUX_W-1:0]    lux_shown;
        logic [TEMP_W-1:0]   temp_held;
        logic [HUM_W-1:0]    hum_held;
        logic                room_on;
        logic [RUN_W-1:0]    run_len;
        logic [TS_W-1:0]     room_seen_ms;
        logic                bed_on;
        logic                bed_cand;
        logic [TS_W-1:0]     bed_since_ms;
        logic                tap_armed;
        logic [TS_W-1:0]     tap_ms;
        logic                level_q;

        snapshot_t           snapshots[$];
        int unsigned         errors;
        int unsigned         checked;
        int unsigned         taps;
        int unsigned         room_ticks;
        int unsigned         bed_ticks;

        function new();
            alpha        = RST_LUX_ALPHA;
            hyst         = RST_LUX_HYST;
            needed       = RST_ROOM_NEEDED;
            hold_ms      = RST_ROOM_HOLD;
            threshold    = RST_BED_THRESHOLD;
            settle_ms    = RST_BED_SETTLE;
            window_ms    = RST_TAP_WINDOW;
            phase        = 0;
            lux_avg      = '0;
            lux_shown    = '0;
            temp_held    = '0;
            hum_held     = '0;
            room_on      = 1'b0;
            run_len      = '0;
            room_seen_ms = '0;
            bed_on       = 1'b0;
            bed_cand     = 1'b0;
            bed_since_ms = '0;
            tap_armed    = 1'b0;
            tap_ms       = '0;
            level_q      = 1'b1;
            errors       = 0;
            checked      = 0;
            taps         = 0;
            room_ticks   = 0;
            bed_ticks    = 0;
        endfunction

        function int unsigned pending();
            return snapshots.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_LUX_ALPHA:     alpha     = val[ALPHA_W-1:0];
                REG_LUX_HYST:      hyst      = val[LUX_W-1:0];
                REG_ROOM_NEEDED:   needed    = val[RUN_W-1:0];
                REG_ROOM_HOLD:     hold_ms   = val[TS_W-1:0];
                REG_BED_THRESHOLD: threshold = val[WEIGHT_W-1:0];
                REG_BED_SETTLE:    settle_ms = val[TS_W-1:0];
                REG_TAP_WINDOW:    window_ms = val[WIN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [TEMP_W-1:0] median3(logic [TEMP_W-1:0] a, logic [TEMP_W-1:0] b,
                                            logic [TEMP_W-1:0] c);
            logic signed [TEMP_W-1:0] lo;
            logic signed [TEMP_W-1:0] hi;
            logic signed [TEMP_W-1:0] sc;
            lo = ($signed(a) < $signed(b)) ? a : b;
            hi = ($signed(a) < $signed(b)) ? b : a;
            sc = c;
            if (sc <= lo)
                return lo;
            if (sc >= hi)
                return hi;
            return c;
        endfunction

        function void note_tick(tick_t t);
            logic [63:0]         keep;
            logic [63:0]         mix;
            logic [SMOOTH_W-1:0] shown_q;
            logic [SMOOTH_W-1:0] diff;
            logic [TS_W-1:0]     dt;
            logic                heavy;
            logic                fall;
            logic                pulse;
            snapshot_t           s;
            pulse = 1'b0;

            // Exponential lux average; the shown value moves only past the hysteresis
            if (phase % LUX_EVERY == 0) begin
                keep    = 64'd65536 - 64'(alpha);
                mix     = 64'(lux_avg) * keep + (64'(t.lux) << FRAC_W) * 64'(alpha);
                lux_avg = mix[SMOOTH_W+FRAC_W-1:FRAC_W];
                shown_q = {lux_shown, 16'd0};
                diff    = (lux_avg >= shown_q) ? lux_avg - shown_q : shown_q - lux_avg;
                if (diff >= {hyst, 16'd0})
                    lux_shown = lux_avg[SMOOTH_W-1:FRAC_W];
            end

            // Median temperature and humidity latch
            if (phase % TEMP_EVERY == 0) begin
                temp_held = median3(t.temp_a, t.temp_b, t.temp_c);
                hum_held  = t.humidity;
            end

            // Room presence: qualify on a run of asserts, drop after the hold time
            if (t.presence) begin
                if (run_len < RUN_MAX)
                    run_len++;
                if (run_len >= needed)
                    room_on = 1'b1;
                room_seen_ms = t.stamp;
            end else begin
                run_len = '0;
                dt      = t.stamp - room_seen_ms;
                if (room_on && dt >= hold_ms)
                    room_on = 1'b0;
            end

            // Bed presence follows the weight candidate once it has settled
            if (phase % BED_EVERY == 0) begin
                heavy = (t.weight >= threshold);
                dt    = t.stamp - bed_since_ms;
                if (heavy != bed_cand) begin
                    bed_cand     = heavy;
                    bed_since_ms = t.stamp;
                end else if (dt >= settle_ms) begin
                    bed_on = bed_cand;
                end
            end

            // Double tap: a second falling edge of the line within the window of the first
            fall    = level_q && !t.tap_level;
            dt      = t.stamp - tap_ms;
            level_q = t.tap_level;
            if (!fall) begin
                if (tap_armed && dt > 32'(window_ms))
                    tap_armed = 1'b0;
            end else if (tap_armed && dt <= 32'(window_ms)) begin
                tap_armed = 1'b0;
                tap_ms    = t.stamp;
                pulse     = 1'b1;
            end else begin
                tap_armed = 1'b1;
                tap_ms    = t.stamp;
            end

            phase = (phase + 1) % PHASE_MOD;

            s.lux      = lux_shown;
            s.temp     = temp_held;
            s.humidity = hum_held;
            s.room     = room_on;
            s.bed      = bed_on;
            s.tapped   = pulse;
            s.updated  = t.stamp;
            snapshots.push_back(s);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        endtask

        task check_snapshot(logic [OUT_W-1:0] word);
            snapshot_t got;
            snapshot_t want;
            got = word[OUT_BITS-1:0];
            if (snapshots.size() == 0) begin
                report("snapshot with nothing pending", got.updated, 0);
            end else begin
                want = snapshots.pop_front();
                checked++;
                if (got.tapped)
                    taps++;
                if (got.room)
                    room_ticks++;
                if (got.bed)
                    bed_ticks++;
                if (word[OUT_W-1:OUT_BITS] != '0)
                    report("zero fill", 32'(word[OUT_W-1:OUT_BITS]), 0);
                if (got.lux != want.lux)
                    report("lux_reported", got.lux, want.lux);
                if (got.temp != want.temp)
                    report("temperature_median", got.temp, want.temp);
                if (got.humidity != want.humidity)
                    report("humidity_latched", got.humidity, want.humidity);
                if (got.room != want.room)
                    report("room_present", got.room, want.room);
                if (got.bed != want.bed)
                    report("bed_present", got.bed, want.bed);
                if (got.tapped != want.tapped)
                    report("double_tapped", got.tapped, want.tapped);
                if (got.updated != want.updated)
                    report("updated_ms", got.updated, want.updated);
            end
        endtask
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // Stimulus shaping state
    logic [TS_W-1:0]       gen_stamp;
    logic [LUX_W-1:0]      gen_lux;
    logic [WEIGHT_W-1:0]   gen_threshold;
    logic                  gen_present;
    logic                  gen_heavy;
    logic                  gen_level;
    int unsigned           ticks_sent;
    int unsigned           settings_used;
    bit                    tx_idle_on;
    bit                    rx_idle_on;
    bit                    rx_hold_req;
    int unsigned           idle_cycles;

    tick_scoreboard        sb;

    sensor_tick_conditioner i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Track every handshake: register writes, accepted ticks, returned snapshots
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_tick(s_axis_tdata[$bits(tick_t)-1:0]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_snapshot(m_axis_tdata);
        end
    end

    // Abort when no word moves on any channel for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("sensor_tick_conditioner_tb failed");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic tick_t tick_of(logic [TS_W-1:0] stamp, logic [LUX_W-1:0] lux,
                                      logic [TEMP_W-1:0] a, logic [TEMP_W-1:0] b,
                                      logic [TEMP_W-1:0] c, logic [HUM_W-1:0] hum,
                                      logic pres, logic [WEIGHT_W-1:0] weight,
                                      logic level);
        tick_t t;
        t.stamp     = stamp;
        t.lux       = lux;
        t.temp_a    = a;
        t.temp_b    = b;
        t.temp_c    = c;
        t.humidity  = hum;
        t.presence  = pres;
        t.weight    = weight;
        t.tap_level = level;
        return t;
    endfunction

    // Mostly a plausible sensor stream: regular time steps, runs of presence and
    // weight, tap line toggles; with some noise and jumps mixed in
    function automatic tick_t random_tick();
        tick_t             t;
        int unsigned       r;
        logic [TEMP_W-1:0] base;
        logic [WEIGHT_W:0] w;

        r = $urandom_range(0, 99);
        if (r < 80)
            gen_stamp = gen_stamp + 32'd100;
        else if (r < 92 && r >= 84)
            gen_stamp = gen_stamp + 32'($urandom_range(1, 400));
        else if (r >= 92 && r < 97)
            gen_stamp = gen_stamp + 32'($urandom_range(0, 65536));
        else if (r >= 97)
            gen_stamp = $urandom();
        t.stamp = gen_stamp;

        if ($urandom_range(0, 19) == 0)
            gen_lux = $urandom();
        t.lux = ($urandom_range(0, 9) == 0) ? LUX_W'($urandom())
                                            : gen_lux ^ LUX_W'($urandom_range(0, 255));

        base = $urandom();
        case ($urandom_range(0, 5))
            0: begin
                t.temp_a = $urandom();
                t.temp_b = $urandom();
                t.temp_c = $urandom();
            end
            1: begin
                t.temp_a = base;
                t.temp_b = base;
                t.temp_c = $urandom();
            end
            2: begin
                t.temp_a = $urandom();
                t.temp_b = base;
                t.temp_c = base;
            end
            3: begin
                t.temp_a = base;
                t.temp_b = base;
                t.temp_c = base;
            end
            4: begin
                t.temp_a = 16'h8000;
                t.temp_b = 16'h7FFF;
                t.temp_c = base;
            end
            default: begin
                t.temp_a = base;
                t.temp_b = base + 16'd7;
                t.temp_c = base - 16'd7;
            end
        endcase
        t.humidity = $urandom_range(0, 25600);

        if ($urandom_range(0, 9) == 0)
            gen_present = !gen_present;
        t.presence = ($urandom_range(0, 19) == 0) ? 1'($urandom()) : gen_present;

        // Hover around the threshold so the candidate changes and settles
        if ($urandom_range(0, 24) == 0)
            gen_heavy = !gen_heavy;
        if (gen_heavy) begin
            w        = 21'(gen_threshold) + 21'($urandom_range(0, 2000));
            t.weight = (w > 21'hFFFFF) ? 20'hFFFFF : w[WEIGHT_W-1:0];
        end else if (gen_threshold == '0) begin
            t.weight = '0;
        end else begin
            t.weight = gen_threshold -
                       20'($urandom_range(1, (gen_threshold > 2000) ? 2000 : gen_threshold));
        end
        if ($urandom_range(0, 9) == 0)
            t.weight = $urandom();

        if ($urandom_range(0, 2) == 0)
            gen_level = !gen_level;
        t.tap_level = gen_level;
        return t;
    endfunction

    function automatic knobs_t random_knobs();
        knobs_t k;
        k.alpha     = $urandom();
        k.hyst      = $urandom_range(0, 4096);
        k.needed    = $urandom_range(0, 15);
        k.hold_ms   = $urandom_range(0, 3000);
        k.threshold = $urandom_range(0, 1048575);
        k.settle_ms = $urandom_range(0, 3000);
        k.window_ms = $urandom_range(0, 800);
        return k;
    endfunction

    // Offer one tick and hold it until accepted, then maybe leave a gap
    task automatic send_tick(input tick_t t);
        s_axis_tdata  <= {{(IN_W - $bits(tick_t)){1'b0}}, t};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ticks_sent++;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every snapshot is back and the pipe is empty
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Write one register; valid stays up so writes can go back to back
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Load a full register set; upper data bits carry junk that must be dropped
    task automatic apply_knobs(input knobs_t k, input bit poke_spare);
        put_reg(REG_LUX_ALPHA,     {16'($urandom()), k.alpha});
        put_reg(REG_LUX_HYST,      {8'($urandom()), k.hyst});
        put_reg(REG_ROOM_NEEDED,   {28'($urandom()), k.needed});
        put_reg(REG_ROOM_HOLD,     k.hold_ms);
        put_reg(REG_BED_THRESHOLD, {12'($urandom()), k.threshold});
        put_reg(REG_BED_SETTLE,    k.settle_ms);
        put_reg(REG_TAP_WINDOW,    {16'($urandom()), k.window_ms});
        if (poke_spare)
            put_reg(REG_SPARE, $urandom());
        cfg_valid <= 1'b0;
        gen_threshold = k.threshold;
        settings_used++;
    endtask

    // Edges of every field, tap window and hold/settle boundaries, timestamp wrap
    task automatic run_directed();
        send_tick(tick_of(32'hFFFF_FFFF, 24'hFF_FFFF, 16'h7FFF, 16'h8000, 16'h0000,
                          15'd25600, 1'b1, 20'hF_FFFF, 1'b0));
        send_tick(tick_of(32'd0, 24'd0, 16'd0, 16'd0, 16'd0, 15'd0, 1'b0, 20'd0, 1'b1));
        // second falling edge exactly at the window: pulse
        send_tick(tick_of(32'd299, 24'h000100, 16'h1234, 16'h1234, 16'h8000,
                          15'd100, 1'b1, 20'd100, 1'b0));
        send_tick(tick_of(32'd400, 24'h000200, 16'h0100, 16'h0200, 16'h0300,
                          15'd200, 1'b1, 20'd200, 1'b1));
        send_tick(tick_of(32'd500, 24'h000300, 16'hFF00, 16'h0000, 16'h0100,
                          15'd300, 1'b1, 20'd300, 1'b0));
        send_tick(tick_of(32'd600, 24'h000400, 16'h0001, 16'h0002, 16'h0003,
                          15'd400, 1'b0, 20'd15000, 1'b1));
        // falling edges one past the window apart: no pulse
        send_tick(tick_of(32'd801, 24'h000500, 16'h0004, 16'h0005, 16'h0006,
                          15'd500, 1'b0, 20'd0, 1'b0));
        // absent for exactly the hold time: room clears
        send_tick(tick_of(32'd30500, 24'h000600, 16'h0007, 16'h0008, 16'h0009,
                          15'd600, 1'b0, 20'd0, 1'b1));
        // presence run with weight above, then below the threshold
        for (int k = 0; k < 12; k++)
            send_tick(tick_of(32'd30600 + 32'(k * 100), (k == 2) ? 24'hFF_FFFF : 24'(k * 1000),
                              16'(k), 16'(k + 1), 16'(k + 2), 15'(k * 50), 1'b1,
                              (k < 7) ? 20'd20000 : 20'd14999, 1'b1));
        // lower weight stable for exactly the settle time: bed clears
        send_tick(tick_of(32'd36300, 24'h000080, 16'h0010, 16'h0020, 16'h0030,
                          15'd700, 1'b1, 20'd14999, 1'b1));
        send_tick(tick_of(32'd36400, 24'h000000, 16'h0011, 16'h0021, 16'h0031,
                          15'd800, 1'b0, 20'd0, 1'b0));
        gen_stamp = 32'd36400;
        gen_level = 1'b0;
    endtask

    task automatic run_random(input setting_e which);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            // pick anew every 50 ticks whether each side may idle
            if (i % 50 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (which == SET_DEFAULT && i >= PHASE_ITEMS - QUIET_TAIL)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (which == SET_RANDOM_A && i == 40)
                rx_hold_req = 1'b1;
            if (which == SET_RANDOM_A && i == 100)
                wait_drained();
            send_tick(random_tick());
        end
    endtask

    initial
    begin
        knobs_t k;
        sb            = new();
        gen_stamp     = $urandom();
        gen_lux       = $urandom();
        gen_threshold = RST_BED_THRESHOLD;
        gen_present   = 1'b0;
        gen_heavy     = 1'b0;
        gen_level     = 1'b1;
        ticks_sent    = 0;
        settings_used = 1;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        rx_hold_req   = 1'b0;
        idle_cycles   = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = SET_LOW; p <= SET_DEFAULT; p++)
        begin
            wait_drained();
            case (setting_e'(p))
                SET_LOW: begin
                    k.alpha     = '0;
                    k.hyst      = '0;
                    k.needed    = '0;
                    k.hold_ms   = '0;
                    k.threshold = '0;
                    k.settle_ms = '0;
                    k.window_ms = '0;
                end
                SET_HIGH: begin
                    k.alpha     = '1;
                    k.hyst      = '1;
                    k.needed    = '1;
                    k.hold_ms   = '1;
                    k.threshold = '1;
                    k.settle_ms = '1;
                    k.window_ms = '1;
                    gen_stamp   = 32'hFFFF_F000;
                end
                SET_DEFAULT: begin
                    k.alpha     = RST_LUX_ALPHA;
                    k.hyst      = RST_LUX_HYST;
                    k.needed    = RST_ROOM_NEEDED;
                    k.hold_ms   = RST_ROOM_HOLD;
                    k.threshold = RST_BED_THRESHOLD;
                    k.settle_ms = RST_BED_SETTLE;
                    k.window_ms = RST_TAP_WINDOW;
                end
                default: k = random_knobs();
            endcase
            apply_knobs(k, setting_e'(p) == SET_RANDOM_B);
            run_random(setting_e'(p));
        end

        wait_drained();
        $display("covered %0d ticks under %0d register settings, %0d snapshots compared",
                 ticks_sent, settings_used, sb.checked);
        $display("saw %0d double taps, %0d room and %0d bed occupied snapshots, %0d mismatches",
                 sb.taps, sb.room_ticks, sb.bed_ticks, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("sensor_tick_conditioner_tb passed");
        else
            $display("sensor_tick_conditioner_tb failed");
        $finish;
    end

endmodule
